// ----- hdl/qpmh_pkg.sv -----
// ----------------------------------------------------------------------------
// qpmh_pkg
// Types, command codes and defaults for the quality/position mismatch
// histogram.
// ----------------------------------------------------------------------------
`default_nettype none

package qpmh_pkg;

  localparam int MAX_COLUMN_DEF  = 255;
  localparam int MAX_QUALITY_DEF = 63;
  localparam int COUNT_BITS_DEF  = 32;

  localparam logic [1:0] CMD_OBSERVE = 2'd0;
  localparam logic [1:0] CMD_READ    = 2'd1;
  localparam logic [1:0] CMD_ADD     = 2'd2;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  read_base;
    logic [7:0]  ref_base;
    logic [7:0]  quality;
    logic [7:0]  position;
    logic        last_of_read;
    logic [31:0] add_total;
    logic [31:0] add_mismatch;
    logic [31:0] add_reads;
  } item_t;

  typedef struct packed {
    logic [31:0] total_count;
    logic [31:0] mismatch_count;
    logic [31:0] read_count;
    logic        out_of_range;
  } result_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h61 && c <= 8'h7A) begin
      r = c - 8'h20;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/quality_position_mismatch_histogram.sv -----
// Each word reads its cell from the total and mismatch memories into registers
// as it is taken; the update state then adds, saturates, writes back and loads
// the result register, waiting while a stalled result still occupies it. A new
// word is taken while an earlier result still waits in the result register.
// After reset a clearing pass writes zero to all (MAX_QUALITY+1)*(MAX_COLUMN+1)
// cells (16384 with the defaults), one cell per cycle, with item_stall high.
// ----------------------------------------------------------------------------
// quality_position_mismatch_histogram
// Total and mismatch count tables indexed by quality and read position, plus a
// read counter, all with saturating counters.
// ----------------------------------------------------------------------------
`default_nettype none

module quality_position_mismatch_histogram
  import qpmh_pkg::*;
#(
  parameter int MAX_COLUMN  = MAX_COLUMN_DEF,
  parameter int MAX_QUALITY = MAX_QUALITY_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    item_valid,
  output logic         item_stall,
  input  wire item_t   item,
  output logic         result_valid,
  input  wire logic    result_stall,
  output result_t      result
);

  localparam int ROW_LEN = MAX_COLUMN + 1;
  localparam int CELLS   = (MAX_QUALITY + 1) * ROW_LEN;
  localparam int AB      = $clog2(CELLS);
  localparam int AW      = ((COUNT_BITS > 32) ? COUNT_BITS : 32) + 1;
  localparam logic [AW-1:0] COUNT_MAX = {{(AW - COUNT_BITS){1'b0}}, {COUNT_BITS{1'b1}}};
  localparam logic [AW-1:0] OUT_MAX   = AW'(33'h0_FFFF_FFFF);

  function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] a,
                                                     input logic [31:0] b);
    logic [AW-1:0] s;
    s = AW'(a) + AW'(b);
    if (s > COUNT_MAX) begin
      s = COUNT_MAX;
    end
    return COUNT_BITS'(s);
  endfunction

  function automatic logic [31:0] clip_out(input logic [COUNT_BITS-1:0] v);
    logic [AW-1:0] w;
    w = AW'(v);
    if (w > OUT_MAX) begin
      w = OUT_MAX;
    end
    return 32'(w);
  endfunction

  state_t state, state_next;

  logic [COUNT_BITS-1:0] total_mem [CELLS];
  logic [COUNT_BITS-1:0] mismatch_mem [CELLS];
  logic [COUNT_BITS-1:0] rd_total;
  logic [COUNT_BITS-1:0] rd_mismatch;
  logic [COUNT_BITS-1:0] reads_seen;

  logic [AB-1:0] clr_addr;
  logic [AB-1:0] addr;
  logic [1:0]    command;
  logic          differ;
  logic          last_of_read;
  logic          out_of_range;
  logic [31:0]   add_total;
  logic [31:0]   add_mismatch;
  logic [31:0]   add_reads;

  logic          in_fire;
  logic          exec_go;
  logic          clr_done;
  logic [8:0]    column;
  logic          in_oor;
  logic [AB-1:0] in_addr;
  logic [31:0]   inc_total;
  logic [31:0]   inc_mismatch;
  logic [31:0]   inc_reads;
  logic [COUNT_BITS-1:0] new_total;
  logic [COUNT_BITS-1:0] new_mismatch;
  logic [COUNT_BITS-1:0] new_reads;
  logic          mem_we;
  logic [AB-1:0] mem_waddr;
  logic [COUNT_BITS-1:0] wr_total;
  logic [COUNT_BITS-1:0] wr_mismatch;

  assign in_fire  = item_valid && !item_stall;
  assign exec_go  = (state == ST_EXEC) && (!result_valid || !result_stall);
  assign clr_done = (clr_addr == AB'(CELLS - 1));

  assign column  = {1'b0, item.position} + 9'd1;
  assign in_oor  = ({1'b0, item.quality} > 9'(MAX_QUALITY)) ||
                   (13'(column) > 13'(MAX_COLUMN));
  assign in_addr = AB'(AB'(item.quality) * AB'(ROW_LEN) + AB'(column));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    item_stall = 1'b1;
    unique case (state)
      ST_CLEAR: begin
        if (clr_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        item_stall = 1'b0;
        if (item_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_go) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == ST_CLEAR && !clr_done) begin
      clr_addr <= clr_addr + AB'(1);
    end
  end

  // hold the item for the update cycle
  always_ff @(posedge clk) begin
    if (in_fire) begin
      addr         <= in_addr;
      command      <= item.command;
      differ       <= (fold_case(item.read_base) != fold_case(item.ref_base));
      last_of_read <= item.last_of_read;
      out_of_range <= in_oor;
      add_total    <= item.add_total;
      add_mismatch <= item.add_mismatch;
      add_reads    <= item.add_reads;
    end
  end

  always_comb begin
    inc_total    = '0;
    inc_mismatch = '0;
    inc_reads    = '0;
    case (command)
      CMD_OBSERVE: begin
        inc_total    = 32'd1;
        inc_mismatch = {31'd0, differ};
        inc_reads    = {31'd0, last_of_read};
      end
      CMD_ADD: begin
        inc_total    = add_total;
        inc_mismatch = add_mismatch;
        inc_reads    = add_reads;
      end
      default: ;
    endcase
  end

  assign new_total    = sat_add(rd_total, inc_total);
  assign new_mismatch = sat_add(rd_mismatch, inc_mismatch);
  assign new_reads    = out_of_range ? reads_seen : sat_add(reads_seen, inc_reads);

  assign mem_we      = (state == ST_CLEAR) || (exec_go && !out_of_range);
  assign mem_waddr   = (state == ST_CLEAR) ? clr_addr : addr;
  assign wr_total    = (state == ST_CLEAR) ? '0 : new_total;
  assign wr_mismatch = (state == ST_CLEAR) ? '0 : new_mismatch;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      total_mem[mem_waddr] <= wr_total;
    end
    if (in_fire) begin
      rd_total <= total_mem[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mismatch_mem[mem_waddr] <= wr_mismatch;
    end
    if (in_fire) begin
      rd_mismatch <= mismatch_mem[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reads_seen <= '0;
    end else if (exec_go) begin
      reads_seen <= new_reads;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (exec_go) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      result.total_count    <= out_of_range ? 32'd0 : clip_out(new_total);
      result.mismatch_count <= out_of_range ? 32'd0 : clip_out(new_mismatch);
      result.read_count     <= clip_out(new_reads);
      result.out_of_range   <= out_of_range;
    end
  end

`ifndef SYNTHESIS
  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> state == ST_EXEC)
    else $error("accepted word did not enter the update cycle");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> item_stall)
    else $error("word accepted during clearing pass");

  a_reads_monotonic: assert property (@(posedge clk) disable iff (rst)
    state == ST_EXEC |=> reads_seen >= $past(reads_seen))
    else $error("read counter decreased");

  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    exec_go && out_of_range |=> result.total_count == 32'd0 &&
                                result.mismatch_count == 32'd0)
    else $error("out-of-range result carries counts");
`endif

endmodule

`default_nettype wire

// ----- tb/quality_position_mismatch_histogram_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quality_position_mismatch_histogram_tb
// Drives observe, read, add and spare-command words into the histogram with
// random gaps and result stalls. Each accepted word is run through a cell-level
// predictor of the count tables and read counter. Every returned word is
// compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------

class hist_predictor;
  bit [31:0] total_cells [(qpmh_pkg::MAX_QUALITY_DEF + 1) * (qpmh_pkg::MAX_COLUMN_DEF + 1)];
  bit [31:0] mism_cells [(qpmh_pkg::MAX_QUALITY_DEF + 1) * (qpmh_pkg::MAX_COLUMN_DEF + 1)];
  bit [31:0] reads_seen;
  qpmh_pkg::result_t pending_cells[$];
  int field_errors;

  function bit [31:0] sat_add(bit [31:0] a, bit [31:0] b);
    bit [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function bit [7:0] upper(bit [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
  endfunction

  function void note_item(qpmh_pkg::item_t it);
    qpmh_pkg::result_t r;
    int unsigned col;
    int unsigned idx;
    r = '0;
    col = int'(it.position) + 1;
    if (it.quality > qpmh_pkg::MAX_QUALITY_DEF || col > qpmh_pkg::MAX_COLUMN_DEF) begin
      r.read_count = reads_seen;
      r.out_of_range = 1'b1;
    end else begin
      idx = int'(it.quality) * (qpmh_pkg::MAX_COLUMN_DEF + 1) + col;
      if (it.command == qpmh_pkg::CMD_OBSERVE) begin
        if (upper(it.read_base) != upper(it.ref_base)) begin
          mism_cells[idx] = sat_add(mism_cells[idx], 32'd1);
        end
        total_cells[idx] = sat_add(total_cells[idx], 32'd1);
        if (it.last_of_read) begin
          reads_seen = sat_add(reads_seen, 32'd1);
        end
      end else if (it.command == qpmh_pkg::CMD_ADD) begin
        total_cells[idx] = sat_add(total_cells[idx], it.add_total);
        mism_cells[idx] = sat_add(mism_cells[idx], it.add_mismatch);
        reads_seen = sat_add(reads_seen, it.add_reads);
      end
      r.total_count = total_cells[idx];
      r.mismatch_count = mism_cells[idx];
      r.read_count = reads_seen;
    end
    pending_cells.push_back(r);
  endfunction

  function void report(string what, logic [31:0] want, logic [31:0] got);
    field_errors++;
    if (field_errors <= 10) begin
      $display("mismatch on %s: expected %h, got %h", what, want, got);
    end
  endfunction

  function void check_result(qpmh_pkg::result_t got);
    qpmh_pkg::result_t want;
    if (pending_cells.size() == 0) begin
      report("unexpected word", 32'h0, got.total_count);
      return;
    end
    want = pending_cells.pop_front();
    if (got.total_count !== want.total_count) begin
      report("total_count", want.total_count, got.total_count);
    end
    if (got.mismatch_count !== want.mismatch_count) begin
      report("mismatch_count", want.mismatch_count, got.mismatch_count);
    end
    if (got.read_count !== want.read_count) begin
      report("read_count", want.read_count, got.read_count);
    end
    if (got.out_of_range !== want.out_of_range) begin
      report("out_of_range", {31'h0, want.out_of_range}, {31'h0, got.out_of_range});
    end
  endfunction
endclass

module quality_position_mismatch_histogram_tb
  import qpmh_pkg::*;
();

  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_WORDS = 700;

  logic    clk;
  logic    rst;
  logic    item_valid;
  logic    item_stall;
  item_t   item;
  logic    result_valid;
  logic    result_stall;
  result_t result;

  hist_predictor board;
  int  hold_left;
  bit  long_hold_req;
  bit  send_fast;
  bit  recv_fast;
  int  cycles;

  quality_position_mismatch_histogram dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[quality_position_mismatch_histogram] ERROR");
    $finish;
  end

  // check returned words and pick the next receiver hold
  always @(posedge clk) begin
    if (!rst && result_valid === 1'b1 && result_stall === 1'b0) begin
      board.check_result(result);
      if ($urandom_range(0, 39) == 0) begin
        recv_fast = !recv_fast;
      end
      hold_left = recv_fast ? 0 : $urandom_range(0, 18);
    end
  end

  always @(negedge clk) begin
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left = 600;
    end
    if (hold_left > 0) begin
      result_stall <= 1'b1;
      hold_left--;
    end else begin
      result_stall <= 1'b0;
    end
  end

  function automatic item_t pack_item(logic [1:0] cmd, logic [7:0] rb, logic [7:0] gb,
                                      logic [7:0] q, logic [7:0] p, logic last,
                                      logic [31:0] at, logic [31:0] am, logic [31:0] ar);
    item_t it;
    it.command = cmd;
    it.read_base = rb;
    it.ref_base = gb;
    it.quality = q;
    it.position = p;
    it.last_of_read = last;
    it.add_total = at;
    it.add_mismatch = am;
    it.add_reads = ar;
    return it;
  endfunction

  function automatic int next_gap();
    if ($urandom_range(0, 49) == 0) begin
      send_fast = !send_fast;
    end
    return send_fast ? 0 : $urandom_range(0, 18);
  endfunction

  function automatic item_t draw_item(int n);
    item_t it;
    byte unsigned letters[10] = '{8'h41, 8'h43, 8'h47, 8'h54, 8'h4E,
                                  8'h61, 8'h63, 8'h67, 8'h74, 8'h6E};
    int pick;
    bit hot;
    it.read_base = 8'($urandom);
    it.ref_base = 8'($urandom);
    it.last_of_read = 1'($urandom);
    it.add_total = $urandom;
    it.add_mismatch = $urandom;
    it.add_reads = $urandom;
    hot = 1'b0;
    if ($urandom_range(0, 19) == 0) begin
      if ($urandom_range(0, 1) == 0) begin
        it.quality = 8'($urandom_range(64, 255));
        it.position = 8'($urandom_range(0, 255));
      end else begin
        it.quality = 8'($urandom_range(0, 63));
        it.position = 8'hFF;
      end
    end else if ($urandom_range(0, 3) != 0) begin
      hot = 1'b1;
      it.quality = 8'($urandom_range(0, 3));
      it.position = 8'($urandom_range(0, 3));
    end else begin
      it.quality = 8'($urandom_range(0, 63));
      it.position = 8'($urandom_range(0, 254));
    end
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      it.command = CMD_OBSERVE;
      if ($urandom_range(0, 9) < 8) begin
        it.read_base = letters[$urandom_range(0, 9)];
        it.ref_base = letters[$urandom_range(0, 9)];
      end
      it.last_of_read = ($urandom_range(0, 5) == 0);
    end else if (pick < 75) begin
      it.command = $urandom_range(0, 1) ? CMD_READ : CMD_SPARE;
    end else begin
      it.command = CMD_ADD;
      if (hot || $urandom_range(0, 3) != 0) begin
        it.add_total = $urandom_range(0, 32'hFFFF);
        it.add_mismatch = $urandom_range(0, 32'hFFFF);
      end
      if (n < 650 || $urandom_range(0, 1) == 0) begin
        it.add_reads = $urandom_range(0, 255);
      end
    end
    return it;
  endfunction

  task automatic send_word(input item_t it, input int gap);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    board.note_item(it);
    @(negedge clk);
  endtask

  initial begin
    item_t directed[$];
    int burst_left;
    board = new();
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    result_stall = 1'b0;
    hold_left = 0;
    long_hold_req = 1'b0;
    send_fast = 1'b0;
    recv_fast = 1'b0;
    burst_left = 0;

    directed.push_back(pack_item(CMD_READ, 8'h00, 8'h00, 8'd0, 8'd0, 1'b0, 0, 0, 0));
    directed.push_back(pack_item(CMD_OBSERVE, 8'h41, 8'h61, 8'd0, 8'd0, 1'b0,
                                 $urandom, $urandom, $urandom));
    directed.push_back(pack_item(CMD_OBSERVE, 8'h63, 8'h47, 8'd0, 8'd0, 1'b1,
                                 $urandom, $urandom, $urandom));
    directed.push_back(pack_item(CMD_OBSERVE, 8'h5B, 8'h7B, 8'd0, 8'd0, 1'b0, 0, 0, 0));
    directed.push_back(pack_item(CMD_OBSERVE, 8'h40, 8'h60, 8'd1, 8'd1, 1'b0, 0, 0, 0));
    directed.push_back(pack_item(CMD_OBSERVE, 8'h7A, 8'h5A, 8'd1, 8'd1, 1'b1, 0, 0, 0));
    directed.push_back(pack_item(CMD_OBSERVE, 8'hFF, 8'hFF, 8'd63, 8'd254, 1'b1,
                                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    directed.push_back(pack_item(CMD_OBSERVE, 8'h54, 8'h41, 8'd63, 8'd0, 1'b0, 0, 0, 0));
    directed.push_back(pack_item(CMD_OBSERVE, 8'h41, 8'h43, 8'd64, 8'd0, 1'b1, 0, 0, 0));
    directed.push_back(pack_item(CMD_OBSERVE, 8'h41, 8'h43, 8'd255, 8'd10, 1'b1, 0, 0, 0));
    directed.push_back(pack_item(CMD_OBSERVE, 8'h41, 8'h43, 8'd0, 8'd255, 1'b1, 0, 0, 0));
    directed.push_back(pack_item(CMD_READ, 8'h00, 8'h00, 8'd63, 8'd254, 1'b0, 0, 0, 0));
    directed.push_back(pack_item(CMD_SPARE, 8'($urandom), 8'($urandom), 8'd0, 8'd0, 1'b1,
                                 $urandom, $urandom, $urandom));
    directed.push_back(pack_item(CMD_ADD, 8'h00, 8'h00, 8'd5, 8'd7, 1'b0,
                                 32'hFFFF_FFF0, 32'h7FFF_FFFF, 32'd3));
    directed.push_back(pack_item(CMD_ADD, 8'hFF, 8'h00, 8'd5, 8'd7, 1'b1,
                                 32'h0000_0020, 32'h8000_0001, 32'd0));
    directed.push_back(pack_item(CMD_OBSERVE, 8'h43, 8'h54, 8'd5, 8'd7, 1'b0, 0, 0, 0));
    directed.push_back(pack_item(CMD_SPARE, 8'h00, 8'h00, 8'd5, 8'd7, 1'b0, 0, 0, 0));
    directed.push_back(pack_item(CMD_ADD, 8'h00, 8'h00, 8'd200, 8'd7, 1'b0,
                                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    directed.push_back(pack_item(CMD_ADD, 8'h00, 8'h00, 8'd5, 8'd255, 1'b0,
                                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    directed.push_back(pack_item(CMD_ADD, 8'h00, 8'h00, 8'd2, 8'd3, 1'b0, 0, 0, 0));
    directed.push_back(pack_item(CMD_ADD, 8'h00, 8'h00, 8'd2, 8'd3, 1'b0,
                                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd5));
    directed.push_back(pack_item(CMD_OBSERVE, 8'h6E, 8'h4E, 8'd2, 8'd3, 1'b1, 0, 0, 0));
    directed.push_back(pack_item(CMD_READ, 8'h00, 8'h00, 8'd2, 8'd3, 1'b0, 0, 0, 0));

    repeat (2) @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      send_word(directed[i], next_gap());
    end

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == 300) begin
        @(posedge clk);
        long_hold_req = 1'b1;
        @(negedge clk);
        burst_left = 40;
      end
      if (n == 500) begin
        item_valid <= 1'b0;
        while (board.pending_cells.size() != 0) @(posedge clk);
        @(negedge clk);
      end
      send_word(draw_item(n), (burst_left > 0) ? 0 : next_gap());
      if (burst_left > 0) begin
        burst_left--;
      end
    end
    item_valid <= 1'b0;

    while (board.pending_cells.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (board.pending_cells.size() != 0) begin
      board.report("words never returned", 32'h0, board.pending_cells.size());
    end

    if (board.field_errors == 0) begin
      $display("[quality_position_mismatch_histogram] OK");
    end else begin
      $display("[quality_position_mismatch_histogram] ERROR");
    end
    $finish;
  end
endmodule
